@@ design/midi_dec_pkg.sv @@
`default_nettype none

package midi_dec_pkg;

    typedef enum logic [3:0] {
        KIND_NOTE_OFF       = 4'd0,
        KIND_NOTE_ON        = 4'd1,
        KIND_POLY_PRESSURE  = 4'd2,
        KIND_CONTROL        = 4'd3,
        KIND_PROGRAM        = 4'd4,
        KIND_CHAN_PRESSURE  = 4'd5,
        KIND_PITCH_BEND     = 4'd6,
        KIND_MACHINE_CTRL   = 4'd7,
        KIND_OTHER          = 4'd8
    } kind_t;

    localparam logic [7:0] SYSEX_STATUS = 8'hF0;
    localparam logic [7:0] EOX_BYTE     = 8'hF7;
    localparam logic [7:0] RT_UNIVERSAL = 8'h7F;
    localparam logic [7:0] MMC_SUB_ID   = 8'h06;
    localparam logic [3:0] STATUS_NOTE_OFF   = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON    = 4'h9;
    localparam logic [3:0] STATUS_POLY_PRESS = 4'hA;
    localparam logic [3:0] STATUS_CONTROL    = 4'hB;
    localparam logic [3:0] STATUS_PROGRAM    = 4'hC;
    localparam logic [3:0] STATUS_CHAN_PRESS = 4'hD;
    localparam logic [3:0] STATUS_PITCH_BEND = 4'hE;

    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef struct packed {
        logic        accepted;
        kind_t       kind;
        logic [3:0]  channel;
        logic [7:0]  status_code;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [13:0] bend_value;
        logic [7:0]  unit_id;
        logic [7:0]  mmc_command;
    } result_t;

    // st and b1..b4 are the message bytes including the one being taken now
    function automatic result_t decode_msg(
        input logic [7:0] st,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [7:0] b4,
        input logic [2:0] len,
        input logic [7:0] lastb
    );
        result_t res;
        logic    ok1;
        logic    ok2;
        res = '0;
        ok1 = (len >= 3'd2) && !b1[7];
        ok2 = ok1 && (len >= 3'd3) && !b2[7];
        priority if (st == SYSEX_STATUS) begin
            res.accepted    = 1'b1;
            res.status_code = SYSEX_STATUS;
            if (len >= 3'd6 && b1 == RT_UNIVERSAL && b3 == MMC_SUB_ID && lastb == EOX_BYTE) begin
                res.kind        = KIND_MACHINE_CTRL;
                res.unit_id     = b2;
                res.mmc_command = b4;
            end else begin
                res.kind = KIND_OTHER;
            end
        end else if (!st[7]) begin
            res = '0;
        end else begin
            unique case (st[7:4])
                STATUS_NOTE_OFF, STATUS_NOTE_ON, STATUS_POLY_PRESS, STATUS_CONTROL: begin
                    if (ok2) begin
                        res.accepted    = 1'b1;
                        res.kind        = kind_t'({1'b0, st[6:4]});
                        res.channel     = st[3:0];
                        res.status_code = {st[7:4], 4'h0};
                        res.first_data  = b1[6:0];
                        res.second_data = b2[6:0];
                    end
                end
                STATUS_PROGRAM, STATUS_CHAN_PRESS: begin
                    if (ok1) begin
                        res.accepted    = 1'b1;
                        res.kind        = kind_t'({1'b0, st[6:4]});
                        res.channel     = st[3:0];
                        res.status_code = {st[7:4], 4'h0};
                        res.first_data  = b1[6:0];
                    end
                end
                STATUS_PITCH_BEND: begin
                    if (ok2) begin
                        res.accepted    = 1'b1;
                        res.kind        = KIND_PITCH_BEND;
                        res.channel     = st[3:0];
                        res.status_code = {st[7:4], 4'h0};
                        res.bend_value  = {b2[6:0], b1[6:0]};
                    end
                end
                default: begin
                    res.accepted    = 1'b1;
                    res.kind        = KIND_OTHER;
                    res.channel     = st[3:0];
                    res.status_code = st;
                end
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/midi_message_decoder_core.sv @@
// midi message decoder
// input stream: one message byte per transfer on s_tdata, s_tlast set on the
// final byte of the message. every transferred byte is captured; bytes
// without s_tlast give no result.
// result stream: one decoded result per message, registered at its last byte,
// through the skid register while the output stalls. m_tuser carries the
// accepted flag and the kind, m_tdata the decoded fields; fields unused by a
// kind are zero, and a rejected message (accepted low) has all fields zero.
// throughput: one byte per cycle while s_tready is high, set by the single
// capture-and-decode stage between the byte counter/store and the result register.
// a two-entry output (result register plus skid register) keeps s_tready
// high while one result waits on a stalled receiver; s_tready drops only
// when both entries are full, and comes from a register.
// reset (aresetn low, synchronous) clears the byte count, stored bytes and
// both output entries, so the next byte starts a new message.
`default_nettype none

module midi_message_decoder_core
    import midi_dec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // channel[3:0], status_code[11:4], first_data[18:12], second_data[25:19],
    // bend_value[39:26], unit_id[47:40], mmc_command[55:48]
    output logic [55:0]      m_tdata,
    output logic [4:0]       m_tuser    // accepted[0], kind[4:1]
);

    logic [2:0]      count_reg;
    logic [2:0]      count_next;
    logic [7:0]      status_reg;
    logic [7:0]      status_next;
    logic [3:0][7:0] body_reg;
    logic [3:0][7:0] body_next;
    logic [2:0]      len;

    result_t res;
    logic    s_fire;
    logic    res_valid;
    logic    m_fire;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    assign s_tready  = !skid_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign res_valid = s_fire && s_tlast;
    assign m_fire    = out_valid_reg && m_tready;

    // byte store, including the byte being transferred now
    always_comb begin
        status_next = status_reg;
        body_next   = body_reg;
        if (count_reg == 3'd0) begin
            status_next = s_tdata;
        end
        for (int i = 0; i < 4; i++) begin
            if (count_reg == 3'(i + 1)) begin
                body_next[i] = s_tdata;
            end
        end
        len = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 3'd1;
        count_next = s_tlast ? 3'd0 : len;
    end

    assign res = decode_msg(status_next, body_next[0], body_next[1], body_next[2],
                            body_next[3], len, s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 3'd0;
            status_reg <= 8'h00;
            body_reg   <= '0;
        end else if (s_fire) begin
            count_reg  <= count_next;
            status_reg <= status_next;
            body_reg   <= body_next;
        end
    end

    // output register with skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_fire || !out_valid_reg) begin
            out_valid_next  = skid_valid_reg || res_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : res;
            skid_valid_next = 1'b0;
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_data_reg.kind, out_data_reg.accepted};
    assign m_tdata  = {out_data_reg.mmc_command, out_data_reg.unit_id,
                       out_data_reg.bend_value, out_data_reg.second_data,
                       out_data_reg.first_data, out_data_reg.status_code,
                       out_data_reg.channel};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without a stalled output");

    a_count_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (count_reg == 3'd0))
        else $error("byte count not cleared after last byte");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 56'd0 && m_tuser[4:1] == 4'd0))
        else $error("rejected result carries nonzero fields");

endmodule

`default_nettype wire
